[sv/cfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver package
// Shared types, codes and reset values for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam logic [7:0] StartMarkerRst = 8'd2;
  localparam logic [7:0] EndMarkerRst   = 8'd3;
  localparam logic [8:0] CsumModRst     = 9'd256;
  localparam logic [8:0] SeqModRst      = 9'd16;
  localparam logic [7:0] MaxDataRst     = 8'd250;
  localparam int unsigned QueueDepth    = 4;
  localparam logic [7:0] Overhead       = 8'd5;

  localparam logic [0:0] CmdByte    = 1'b0;
  localparam logic [0:0] CmdConnect = 1'b1;

  localparam logic [0:0] KindData    = 1'b0;
  localparam logic [0:0] KindVerdict = 1'b1;

  localparam logic [2:0] VerNew   = 3'd0;
  localparam logic [2:0] VerDup   = 3'd1;
  localparam logic [2:0] VerOos   = 3'd2;
  localparam logic [2:0] VerCsum  = 3'd3;
  localparam logic [2:0] VerNoEnd = 3'd4;
  localparam logic [2:0] VerShort = 3'd5;

  localparam logic [2:0] RegStart  = 3'd0;
  localparam logic [2:0] RegEnd    = 3'd1;
  localparam logic [2:0] RegCsum   = 3'd2;
  localparam logic [2:0] RegSeqMod = 3'd3;
  localparam logic [2:0] RegMaxDat = 3'd4;

  // Request classes passed from front to back.
  localparam logic [1:0] OpData  = 2'd0;
  localparam logic [1:0] OpShort = 2'd1;
  localparam logic [1:0] OpEnd   = 2'd2;
  localparam logic [1:0] OpConn  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data;
    logic [7:0]  seq;
    logic [7:0]  count;
    logic [15:0] sum;
    logic [7:0]  check;
    logic        end_ok;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] verdict;
    logic [7:0] frame_seq;
    logic       ack_send;
    logic [7:0] ack_seq;
    logic [7:0] data_count;
  } res_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [8:0] checksum_modulus;
    logic [8:0] seq_modulus;
    logic [7:0] max_data_bytes;
  } cfg_t;

endpackage

[sv/cfr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver channels
// Valid/ready channels for input bytes and results.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] verdict;
  logic [7:0] frame_seq;
  logic       ack_send;
  logic [7:0] ack_seq;
  logic [7:0] data_count;
  modport source (output valid, result_kind, data_byte, verdict, frame_seq, ack_send,
                  ack_seq, data_count, input ready);
  modport sink (input valid, result_kind, data_byte, verdict, frame_seq, ack_send,
                ack_seq, data_count, output ready);
endinterface

[sv/checksum_frame_receiver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver top level
// Stop-and-wait receive framing with modular byte-sum checksum.
// ----------------------------------------------------------------------------
// Ordinary bytes are taken one per cycle while the request queue has room,
// and a data byte's result passes through the request queue and is then
// registered in the back end. The verdict for the end-marker byte passes
// through the request queue, 17 bit-serial subtract steps of the modulo of
// the 16-bit byte sum, and the register that holds the verdict. The back end
// takes no new request until a verdict is out; a four-entry request queue
// lets the framing front end keep taking bytes meanwhile.
module checksum_frame_receiver_top #(
  parameter int unsigned Depth = cfr_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  cfr_in_if.sink      in_ch,
  cfr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfr_pkg::*;

  cfg_t       cfg;
  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  cmd_t       fq_cmd, bq_cmd;
  res_t       res;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= StartMarkerRst;
      cfg.end_marker <= EndMarkerRst;
      cfg.checksum_modulus <= CsumModRst;
      cfg.seq_modulus <= SeqModRst;
      cfg.max_data_bytes <= MaxDataRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegStart:  cfg.start_marker <= pwdata[7:0];
        RegEnd:    cfg.end_marker <= pwdata[7:0];
        RegCsum:   cfg.checksum_modulus <= pwdata[8:0];
        RegSeqMod: cfg.seq_modulus <= pwdata[8:0];
        RegMaxDat: cfg.max_data_bytes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegStart:  prdata = {24'd0, cfg.start_marker};
      RegEnd:    prdata = {24'd0, cfg.end_marker};
      RegCsum:   prdata = {23'd0, cfg.checksum_modulus};
      RegSeqMod: prdata = {23'd0, cfg.seq_modulus};
      RegMaxDat: prdata = {24'd0, cfg.max_data_bytes};
      default:   prdata = '0;
    endcase
  end

  cfr_front u_front (
    .clk, .rst, .cfg,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .command (in_ch.command), .rx_byte (in_ch.rx_byte),
    .q_valid (fq_valid), .q_ready (fq_ready), .q_cmd (fq_cmd)
  );

  cfr_fifo #(.Depth(Depth)) u_fifo (
    .clk, .rst,
    .wr_valid (fq_valid), .wr_ready (fq_ready), .wr_data (fq_cmd),
    .rd_valid (bq_valid), .rd_ready (bq_ready), .rd_data (bq_cmd)
  );

  cfr_back u_back (
    .clk, .rst, .cfg,
    .q_valid (bq_valid), .q_ready (bq_ready), .q_cmd (bq_cmd),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_res (res)
  );

  assign out_ch.result_kind = res.result_kind;
  assign out_ch.data_byte   = res.data_byte;
  assign out_ch.verdict     = res.verdict;
  assign out_ch.frame_seq   = res.frame_seq;
  assign out_ch.ack_send    = res.ack_send;
  assign out_ch.ack_seq     = res.ack_seq;
  assign out_ch.data_count  = res.data_count;
endmodule

[sv/cfr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver front end
// Framing state machine: hunts, parses size and sequence, sums bytes and
// emits requests for the back end.
// ----------------------------------------------------------------------------
module cfr_front (
  input  logic          clk,
  input  logic          rst,
  input  cfr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [7:0]    rx_byte,
  output logic          q_valid,
  input  logic          q_ready,
  output cfr_pkg::cmd_t q_cmd
);
  import cfr_pkg::*;

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhSize  = 3'd1;
  localparam logic [2:0] PhSeq   = 3'd2;
  localparam logic [2:0] PhData  = 3'd3;
  localparam logic [2:0] PhCheck = 3'd4;
  localparam logic [2:0] PhEnd   = 3'd5;

  logic        link_up;
  logic [2:0]  phase;
  logic [7:0]  frame_length;
  logic [7:0]  byte_index;
  logic [15:0] running_sum;
  logic [7:0]  received_seq;
  logic [7:0]  received_check;
  logic        take;
  logic [7:0]  data_len;
  logic [7:0]  idx_inc;

  assign in_ready = q_ready;
  assign take     = in_valid && q_ready;
  assign data_len = frame_length - Overhead;
  assign idx_inc  = byte_index + 8'd1;

  always_comb begin
    q_valid = 1'b0;
    q_cmd   = '0;
    q_cmd.data = rx_byte;
    q_cmd.seq  = received_seq;
    q_cmd.sum  = running_sum;
    q_cmd.check = received_check;
    q_cmd.end_ok = (rx_byte == cfg.end_marker);
    q_cmd.count = (data_len < cfg.max_data_bytes) ? data_len : cfg.max_data_bytes;
    if (in_valid) begin
      if (command == CmdConnect) begin
        q_valid = 1'b1;
        q_cmd.op = OpConn;
      end else if (link_up) begin
        unique case (phase)
          PhSize: begin
            if (rx_byte < Overhead) begin
              q_valid = 1'b1;
              q_cmd.op = OpShort;
            end
          end
          PhData: begin
            if (byte_index < cfg.max_data_bytes) begin
              q_valid = 1'b1;
              q_cmd.op = OpData;
              q_cmd.count = idx_inc;
            end
          end
          PhEnd: begin
            q_valid = 1'b1;
            q_cmd.op = OpEnd;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up <= 1'b0;
      phase <= PhHunt;
      frame_length <= '0;
      byte_index <= '0;
      running_sum <= '0;
      received_seq <= '0;
      received_check <= '0;
    end else if (take) begin
      if (command == CmdConnect) begin
        link_up <= 1'b1;
        phase <= PhHunt;
      end else if (link_up) begin
        unique case (phase)
          PhHunt: if (rx_byte == cfg.start_marker) phase <= PhSize;
          PhSize: begin
            if (rx_byte < Overhead) begin
              phase <= PhHunt;
            end else begin
              frame_length <= rx_byte;
              running_sum <= {8'd0, rx_byte};
              phase <= PhSeq;
            end
          end
          PhSeq: begin
            received_seq <= rx_byte;
            running_sum <= running_sum + {8'd0, rx_byte};
            byte_index <= '0;
            phase <= (frame_length == Overhead) ? PhCheck : PhData;
          end
          PhData: begin
            running_sum <= running_sum + {8'd0, rx_byte};
            byte_index <= idx_inc;
            if (idx_inc >= data_len) phase <= PhCheck;
          end
          PhCheck: begin
            received_check <= rx_byte;
            phase <= PhEnd;
          end
          PhEnd: phase <= PhHunt;
          default: phase <= PhHunt;
        endcase
      end
    end
  end
endmodule

[sv/cfr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver request queue
// Small register queue between front and back end.
// ----------------------------------------------------------------------------
module cfr_fifo #(
  parameter int unsigned Depth = cfr_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cfr_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cfr_pkg::cmd_t rd_data
);
  import cfr_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem [Depth];
  logic [Aw-1:0] wptr;
  logic [Aw-1:0] rptr;
  logic [Aw:0]   fill;
  logic          push;
  logic          pop;

  assign wr_ready = (fill != Aw'(0) + (Aw+1)'(Depth));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + Aw'(1);
      if (pop) rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + Aw'(1);
      fill <= fill + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule

[sv/cfr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksum frame receiver back end
// Reduces the byte sum by the checksum modulus one bit per cycle, checks
// the sequence and drives the result register.
// ----------------------------------------------------------------------------
module cfr_back (
  input  logic          clk,
  input  logic          rst,
  input  cfr_pkg::cfg_t cfg,
  input  logic          q_valid,
  output logic          q_ready,
  input  cfr_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output cfr_pkg::res_t out_res
);
  import cfr_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]  state;
  logic [15:0] rem;
  logic [24:0] div_sh;
  logic [8:0]  seq_rem;
  logic [16:0] seq_div;
  logic [4:0]  bit_cnt;
  cmd_t        cur;
  logic [7:0]  last_seq;
  logic        last_seq_valid;
  logic [8:0]  cm;
  logic [8:0]  sm;
  logic [8:0]  expected;
  logic [8:0]  seq_inc;
  logic [7:0]  held;
  logic        out_free;
  logic        out_load;
  logic        sum_ok;
  logic        seq_new;
  logic        seq_dup;
  res_t        res;

  assign cm       = (cfg.checksum_modulus == 9'd0) ? 9'd1 : cfg.checksum_modulus;
  assign sm       = (cfg.seq_modulus < 9'd2) ? 9'd2 : cfg.seq_modulus;
  assign seq_inc  = {1'b0, last_seq} + 9'd1;
  assign expected = last_seq_valid ? seq_rem : 9'd0;
  assign held     = last_seq_valid ? last_seq : 8'd255;
  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == StIdle) && out_free;
  assign sum_ok   = (rem == {8'd0, cur.check});
  assign seq_new  = ({1'b0, cur.seq} == expected);
  assign seq_dup  = last_seq_valid && (cur.seq == last_seq);
  assign out_load = ((state == StIdle) && q_valid && q_ready &&
                     (q_cmd.op == OpData || q_cmd.op == OpShort)) ||
                    ((state == StDone) && out_free);

  always_comb begin
    res = '0;
    res.result_kind = KindVerdict;
    res.frame_seq   = cur.seq;
    res.data_count  = cur.count;
    res.ack_seq     = held;
    if (!sum_ok) begin
      res.verdict = VerCsum;
    end else if (!cur.end_ok) begin
      res.verdict = VerNoEnd;
    end else if (seq_new) begin
      res.verdict = VerNew;
      res.ack_send = 1'b1;
      res.ack_seq = cur.seq;
    end else if (seq_dup) begin
      res.verdict = VerDup;
      res.ack_send = 1'b1;
      res.ack_seq = cur.seq;
    end else begin
      res.verdict = VerOos;
      res.ack_send = 1'b1;
    end
  end

  // The expected sequence (last + 1) mod sm is reduced alongside the byte sum,
  // over the last nine steps of the loop.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cur <= q_cmd;
    if (state == StIdle && q_valid && q_ready && q_cmd.op == OpEnd) begin
      rem <= q_cmd.sum;
      div_sh <= {cm, 16'd0};
      seq_rem <= seq_inc;
      seq_div <= {sm, 8'd0};
    end else if (state == StMod) begin
      if ({9'd0, rem} >= div_sh) rem <= rem - div_sh[15:0];
      div_sh <= div_sh >> 1;
      if (bit_cnt <= 5'd8) begin
        if ({8'd0, seq_rem} >= seq_div) seq_rem <= seq_rem - seq_div[8:0];
        seq_div <= seq_div >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      bit_cnt <= '0;
      out_valid <= 1'b0;
      last_seq <= '0;
      last_seq_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (q_valid && q_ready) begin
            case (q_cmd.op)
              OpConn: begin
                last_seq <= '0;
                last_seq_valid <= 1'b0;
              end
              OpData: begin
                out_res <= '{result_kind: KindData, data_byte: q_cmd.data, verdict: VerNew,
                             frame_seq: q_cmd.seq, ack_send: 1'b0, ack_seq: 8'd0,
                             data_count: q_cmd.count};
              end
              OpShort: begin
                out_res <= '{result_kind: KindVerdict, data_byte: 8'd0, verdict: VerShort,
                             frame_seq: 8'd0, ack_send: 1'b0, ack_seq: held,
                             data_count: 8'd0};
              end
              default: begin
                state <= StMod;
                bit_cnt <= 5'd16;
              end
            endcase
          end
        end
        StMod: begin
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) state <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_res <= res;
            if (sum_ok && cur.end_ok && seq_new) begin
              last_seq <= cur.seq;
              last_seq_valid <= 1'b1;
            end
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

[tb/cfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the request and result channels, predicts every result from the
// accepted requests and the current register values, and compares them.
// ----------------------------------------------------------------------------
module cfr_checker
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_res,
  input  cfg_t        cfg,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    Hunt, Size, Seq, Data, Check, EndByte
  } phase_e;

  res_t   expected_q[$];
  logic   link_up;
  phase_e phase;
  logic [7:0]  frame_len;
  logic [7:0]  byte_idx;
  logic [15:0] byte_sum;
  logic [7:0]  frame_seq_r;
  logic [7:0]  frame_check;
  logic [7:0]  last_seq;
  logic        last_valid;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [7:0] held_ack();
    return last_valid ? last_seq : 8'd255;
  endfunction

  task automatic clear_frame();
    phase = Hunt;
    frame_len = 0;
    byte_idx = 0;
    byte_sum = 0;
    frame_seq_r = 0;
    frame_check = 0;
  endtask

  task automatic add_verdict(input logic [2:0] v, input logic [7:0] fs, input logic snd,
                             input logic [7:0] as, input logic [7:0] cnt);
    res_t r;
    r = '0;
    r.result_kind = KindVerdict;
    r.verdict = v;
    r.frame_seq = fs;
    r.ack_send = snd;
    r.ack_seq = as;
    r.data_count = cnt;
    expected_q.push_back(r);
  endtask

  task automatic predict_byte(input logic cmd, input logic [7:0] b);
    res_t r;
    int unsigned cm, sm, expect_seq, cnt;
    logic [7:0] sq;
    logic sum_ok, end_ok;
    if (cmd == CmdConnect) begin
      link_up = 1;
      last_seq = 0;
      last_valid = 0;
      clear_frame();
      return;
    end
    if (!link_up) return;
    case (phase)
      Hunt: begin
        if (b == cfg.start_marker) phase = Size;
      end
      Size: begin
        if (b < Overhead) begin
          clear_frame();
          add_verdict(VerShort, 8'd0, 1'b0, held_ack(), 8'd0);
        end else begin
          frame_len = b;
          byte_sum = b;
          phase = Seq;
        end
      end
      Seq: begin
        frame_seq_r = b;
        byte_sum += b;
        byte_idx = 0;
        phase = (frame_len == Overhead) ? Check : Data;
      end
      Data: begin
        byte_sum += b;
        if (byte_idx < cfg.max_data_bytes) begin
          r = '0;
          r.result_kind = KindData;
          r.data_byte = b;
          r.frame_seq = frame_seq_r;
          r.data_count = byte_idx + 8'd1;
          expected_q.push_back(r);
        end
        byte_idx++;
        if (byte_idx >= frame_len - Overhead) phase = Check;
      end
      Check: begin
        frame_check = b;
        phase = EndByte;
      end
      default: begin
        cm = (cfg.checksum_modulus == 0) ? 1 : cfg.checksum_modulus;
        sm = (cfg.seq_modulus < 2) ? 2 : cfg.seq_modulus;
        sq = frame_seq_r;
        cnt = frame_len - Overhead;
        if (cnt > cfg.max_data_bytes) cnt = cfg.max_data_bytes;
        expect_seq = last_valid ? (last_seq + 1) % sm : 0;
        sum_ok = (byte_sum % cm) == frame_check;
        end_ok = (b == cfg.end_marker);
        clear_frame();
        if (!sum_ok) add_verdict(VerCsum, sq, 1'b0, held_ack(), 8'(cnt));
        else if (!end_ok) add_verdict(VerNoEnd, sq, 1'b0, held_ack(), 8'(cnt));
        else if (sq == expect_seq) begin
          last_seq = sq;
          last_valid = 1;
          add_verdict(VerNew, sq, 1'b1, sq, 8'(cnt));
        end else if (last_valid && sq == last_seq) add_verdict(VerDup, sq, 1'b1, sq, 8'(cnt));
        else add_verdict(VerOos, sq, 1'b1, held_ack(), 8'(cnt));
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      link_up = 0;
      last_seq = 0;
      last_valid = 0;
      clear_frame();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          e = expected_q.pop_front();
          if (out_res.result_kind !== e.result_kind) report("result_kind");
          if (out_res.data_byte !== e.data_byte) report("data_byte");
          if (out_res.verdict !== e.verdict) report("verdict");
          if (out_res.frame_seq !== e.frame_seq) report("frame_seq");
          if (out_res.ack_send !== e.ack_send) report("ack_send");
          if (out_res.ack_seq !== e.ack_seq) report("ack_seq");
          if (out_res.data_count !== e.data_count) report("data_count");
        end
      end
      if (in_valid && in_ready) predict_byte(in_command, in_rx_byte);
    end
    pending = expected_q.size();
  end

endmodule

[tb/checksum_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Drives directed and random framed byte streams under several register
// settings with random idling on both channels; a checker compares results.
// ----------------------------------------------------------------------------
module checksum_frame_receiver_top_tb;
  import cfr_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  cfg_t cfg;
  int   fail_count, pending;
  int   items;
  bit   steady;

  cfr_in_if  in_ch();
  cfr_out_if out_ch();
  res_t out_res;

  assign out_res = '{out_ch.result_kind, out_ch.data_byte, out_ch.verdict, out_ch.frame_seq,
                     out_ch.ack_send, out_ch.ack_seq, out_ch.data_count};

  checksum_frame_receiver_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cfr_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_rx_byte(in_ch.rx_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_res),
    .cfg(cfg), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 22);
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      RegStart:  cfg.start_marker = val[7:0];
      RegEnd:    cfg.end_marker = val[7:0];
      RegCsum:   cfg.checksum_modulus = val[8:0];
      RegSeqMod: cfg.seq_modulus = val[8:0];
      default:   cfg.max_data_bytes = val[7:0];
    endcase
  endtask

  task automatic send(input logic cmd, input logic [7:0] b);
    while (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One frame; the corruption code selects a checksum or end-marker fault.
  task automatic send_frame(input int ndata, input logic [7:0] sq, input int fault);
    logic [15:0] sum;
    logic [7:0]  d;
    int unsigned cm;
    cm = (cfg.checksum_modulus == 0) ? 1 : cfg.checksum_modulus;
    send(CmdByte, cfg.start_marker);
    send(CmdByte, 8'(ndata + 5));
    send(CmdByte, sq);
    sum = 16'(ndata + 5 + sq);
    for (int i = 0; i < ndata; i++) begin
      d = 8'($urandom);
      sum += d;
      send(CmdByte, d);
    end
    d = 8'(sum % cm);
    if (fault == 1) d = d + 8'd1;
    send(CmdByte, d);
    send(CmdByte, fault == 2 ? cfg.end_marker ^ 8'h5a : cfg.end_marker);
  endtask

  task automatic random_phase(input int n);
    logic [7:0] next_seq;
    int r, nd;
    next_seq = 0;
    while (n > 0) begin
      r = $urandom_range(99);
      nd = ($urandom_range(9) == 0) ? $urandom_range(250) : $urandom_range(12);
      if (r < 3) begin
        send(CmdConnect, 8'($urandom));
        next_seq = 0;
        n--;
      end else if (r < 10) begin
        send(CmdByte, 8'($urandom));
        n--;
      end else if (r < 14) begin
        send(CmdByte, cfg.start_marker);
        send(CmdByte, 8'($urandom_range(4)));
        n -= 2;
      end else begin
        r = $urandom_range(99);
        send_frame(nd, r < 70 ? next_seq : (r < 85 ? next_seq - 8'd1 : 8'($urandom)),
                   r >= 90 ? $urandom_range(1, 2) : 0);
        if (r < 70) begin
          next_seq = 8'((next_seq + 1) % ((cfg.seq_modulus < 2) ? 2 : cfg.seq_modulus));
        end
        n -= nd + 5;
      end
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.command = 0;
    in_ch.rx_byte = 0;
    cfg = '{StartMarkerRst, EndMarkerRst, CsumModRst, SeqModRst, MaxDataRst};
    steady = 0;
    items = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: bytes before connect, short sizes, minimal and faulty frames.
    send(CmdByte, StartMarkerRst);
    send(CmdByte, 8'hff);
    send(CmdConnect, 8'h00);
    send(CmdByte, StartMarkerRst);
    send(CmdByte, 8'd0);
    send(CmdByte, StartMarkerRst);
    send(CmdByte, 8'd4);
    send_frame(0, 8'd0, 0);
    send_frame(1, 8'd0, 0);
    send_frame(2, 8'd5, 0);
    send_frame(1, 8'd1, 1);
    send_frame(1, 8'd1, 2);
    send_frame(1, 8'd255, 0);
    drain();

    reg_write(RegStart, 32'hff);
    reg_write(RegEnd, 32'h00);
    reg_write(RegCsum, 32'd1);
    reg_write(RegSeqMod, 32'd2);
    reg_write(RegMaxDat, 32'd0);
    send(CmdConnect, 8'hff);
    random_phase(300);
    drain();

    reg_write(RegStart, 32'h00);
    reg_write(RegEnd, 32'hff);
    reg_write(RegCsum, 32'd256);
    reg_write(RegSeqMod, 32'd256);
    reg_write(RegMaxDat, 32'd250);
    steady = 1;
    send(CmdConnect, 8'h00);
    random_phase(350);
    steady = 0;
    drain();

    reg_write(RegStart, 32'h7e);
    reg_write(RegEnd, 32'h81);
    reg_write(RegCsum, 32'd0);
    reg_write(RegSeqMod, 32'd511);
    reg_write(RegMaxDat, 32'd3);
    send(CmdConnect, 8'h00);
    random_phase(300);
    drain();

    reg_write(RegCsum, 32'd511);
    reg_write(RegSeqMod, 32'd1);
    reg_write(RegMaxDat, 32'd6);
    send(CmdConnect, 8'h00);
    random_phase(200);
    drain();

    reg_write(RegStart, StartMarkerRst);
    reg_write(RegEnd, EndMarkerRst);
    reg_write(RegCsum, 32'd97);
    reg_write(RegSeqMod, 32'd16);
    send(CmdConnect, 8'h00);
    random_phase(450);
    drain();

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
sv/cfr_pkg.sv
sv/cfr_if.sv
sv/cfr_front.sv
sv/cfr_fifo.sv
sv/cfr_back.sv
sv/checksum_frame_receiver_top.sv
tb/cfr_checker.sv
tb/checksum_frame_receiver_top_tb.sv
